>>> rtl/core/bsel_pkg.sv
// Package for the clock multiplier button selector.
// Holds the phase type, configuration and result structs, shared constants and count_load.
// No dependencies.
package bsel_pkg;

    // Width of the tick counter that times debounce, hold and reset pulses.
    localparam int COUNT_W = 16;
    localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_MULT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MODE_DELAY = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE      = 2'd3;
    localparam int CFG_DATA_W = 16;

    // Configuration reset values.
    localparam logic [7:0]  INIT_MULT_RST  = 8'd1;
    localparam logic [15:0] DEBOUNCE_RST   = 16'd25;
    localparam logic [15:0] MODE_DELAY_RST = 16'd500;
    localparam logic [15:0] PULSE_RST      = 16'd150;

    // Multiplier code limits.
    localparam logic [2:0] CODE_MIN = 3'd1;
    localparam logic [2:0] CODE_MAX = 3'd3;

    typedef enum logic [2:0] {
        PH_INIT     = 3'd0,
        PH_UPDATE   = 3'd1,
        PH_IDLE     = 3'd2,
        PH_DEBOUNCE = 3'd3,
        PH_CHECK    = 3'd4,
        PH_NEXT     = 3'd5,
        PH_PULSE    = 3'd6
    } phase_t;

    typedef struct packed {
        logic [7:0]  initial_multiplier;
        logic [15:0] debounce_ticks;
        logic [15:0] mode_delay_ticks;
        logic [15:0] reset_pulse_ticks;
    } cfg_t;

    typedef struct packed {
        logic       mult_pin_low;
        logic       mult_pin_high;
        logic       led_low;
        logic       led_high;
        logic       console_reset;
        logic       save_strobe;
        logic [1:0] save_value;
    } result_t;

    // Loads a tick count into the counter, keeping the bits that fit.
    function automatic logic [COUNT_W-1:0] count_load(input logic [15:0] v);
        return COUNT_W'(v);
    endfunction

endpackage

>>> rtl/core/bsel_cfg.sv
// Configuration register file of the clock multiplier button selector.
// Depends on bsel_pkg.
module bsel_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [bsel_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bsel_pkg::CFG_DATA_W-1:0]  cfg_data,
    output bsel_pkg::cfg_t                   cfg
);
    import bsel_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_INIT_MULT:  cfg_next.initial_multiplier = cfg_data[7:0];
                REG_DEBOUNCE:   cfg_next.debounce_ticks     = cfg_data;
                REG_MODE_DELAY: cfg_next.mode_delay_ticks   = cfg_data;
                REG_PULSE:      cfg_next.reset_pulse_ticks  = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.initial_multiplier <= INIT_MULT_RST;
            cfg_reg.debounce_ticks     <= DEBOUNCE_RST;
            cfg_reg.mode_delay_ticks   <= MODE_DELAY_RST;
            cfg_reg.reset_pulse_ticks  <= PULSE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/core/bsel_fsm.sv
// Per-tick state machine of the clock multiplier button selector.
// Updates the phase, code, counter and pin levels for each accepted word.
// Depends on bsel_pkg.
module bsel_fsm (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic              button_pressed,
    input  bsel_pkg::cfg_t    cfg,
    output bsel_pkg::result_t result
);
    import bsel_pkg::*;

    phase_t               phase_reg, phase_next;
    logic [2:0]           code_reg, code_next;
    logic                 locked_reg, locked_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic                 pin_lo_reg, pin_lo_next;
    logic                 pin_hi_reg, pin_hi_next;
    logic [1:0]           led_reg, led_next;
    logic                 rst_lvl_reg, rst_lvl_next;
    logic                 strobe;
    logic [1:0]           sval;
    logic                 count_zero;
    logic [2:0]           code_fixed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_INIT;
            code_reg    <= '0;
            locked_reg  <= 1'b0;
            count_reg   <= '0;
            pin_lo_reg  <= 1'b0;
            pin_hi_reg  <= 1'b0;
            led_reg     <= '0;
            rst_lvl_reg <= 1'b1;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            code_reg    <= code_next;
            locked_reg  <= locked_next;
            count_reg   <= count_next;
            pin_lo_reg  <= pin_lo_next;
            pin_hi_reg  <= pin_hi_next;
            led_reg     <= led_next;
            rst_lvl_reg <= rst_lvl_next;
        end
    end

    assign count_zero = (count_reg == '0);
    // A code stepped past the top wraps back to the lowest speed-up code.
    assign code_fixed = (code_reg > CODE_MAX) ? CODE_MIN : code_reg;

    always_comb
    begin
        phase_next   = phase_reg;
        code_next    = code_reg;
        locked_next  = locked_reg;
        count_next   = count_reg;
        pin_lo_next  = pin_lo_reg;
        pin_hi_next  = pin_hi_reg;
        led_next     = led_reg;
        rst_lvl_next = rst_lvl_reg;
        strobe       = 1'b0;
        sval         = 2'd0;

        unique case (phase_reg)
            PH_INIT:
            begin
                code_next  = (cfg.initial_multiplier > 8'(CODE_MAX)) ?
                             CODE_MIN : cfg.initial_multiplier[2:0];
                phase_next = PH_UPDATE;
            end
            PH_UPDATE:
            begin
                code_next = code_fixed;
                led_next  = code_fixed[1:0];
                if (locked_reg)
                begin
                    count_next = count_load(cfg.mode_delay_ticks);
                    phase_next = PH_NEXT;
                end
                else
                begin
                    pin_lo_next  = code_fixed[0];
                    pin_hi_next  = code_fixed[1];
                    strobe       = 1'b1;
                    sval         = code_fixed[1:0];
                    rst_lvl_next = 1'b0;
                    locked_next  = 1'b1;
                    phase_next   = PH_IDLE;
                end
            end
            PH_IDLE:
            begin
                if (button_pressed)
                begin
                    count_next = count_load(cfg.debounce_ticks);
                    phase_next = PH_DEBOUNCE;
                end
            end
            PH_DEBOUNCE:
            begin
                if (!count_zero)
                begin
                    count_next = count_reg - COUNT_ONE;
                end
                else if (button_pressed)
                begin
                    count_next = count_load(cfg.mode_delay_ticks);
                    phase_next = PH_CHECK;
                end
                else
                begin
                    phase_next = PH_IDLE;
                end
            end
            PH_CHECK:
            begin
                if (button_pressed)
                begin
                    if (!count_zero)
                        count_next = count_reg - COUNT_ONE;
                    else
                        phase_next = PH_NEXT;
                end
                else
                begin
                    rst_lvl_next = 1'b1;
                    count_next   = count_load(cfg.reset_pulse_ticks);
                    phase_next   = PH_PULSE;
                end
            end
            PH_NEXT:
            begin
                if (button_pressed)
                begin
                    if (!count_zero)
                    begin
                        count_next = count_reg - COUNT_ONE;
                    end
                    else
                    begin
                        code_next  = code_reg + 3'd1;
                        phase_next = PH_UPDATE;
                    end
                end
                else
                begin
                    strobe     = 1'b1;
                    sval       = code_reg[1:0];
                    phase_next = PH_IDLE;
                end
            end
            PH_PULSE:
            begin
                if (!count_zero)
                begin
                    count_next = count_reg - COUNT_ONE;
                end
                else
                begin
                    rst_lvl_next = 1'b0;
                    phase_next   = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    always_comb
    begin
        result.mult_pin_low  = pin_lo_next;
        result.mult_pin_high = pin_hi_next;
        result.led_low       = led_next[0];
        result.led_high      = led_next[1];
        result.console_reset = rst_lvl_next;
        result.save_strobe   = strobe;
        result.save_value    = sval;
    end

endmodule

>>> rtl/core/bsel_out.sv
// Output register of the clock multiplier button selector.
// Holds one result word until the receiver takes it. Depends on bsel_pkg.
module bsel_out (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  bsel_pkg::result_t result_in,
    output logic              space,
    output logic              out_valid,
    input  logic              out_ready,
    output bsel_pkg::result_t result_out
);
    import bsel_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    // The register can take a new word when empty or when its word leaves now.
    assign space      = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= result_in;
    end

    assign out_valid  = valid_reg;
    assign result_out = data_reg;

endmodule

>>> rtl/core/clock_multiplier_button_selector_core.sv
// Top level of the clock multiplier button selector.
// Instantiates bsel_cfg, bsel_fsm and bsel_out; depends on bsel_pkg.
//
// Usage:
// Each input word is one timer tick carrying the level of the reset button
// (button_pressed). Each accepted tick yields exactly one result word with the
// multiplier pins, the LED levels, the console reset level and a save request.
// The input channel (in_valid/in_ready) and the output channel
// (out_valid/out_ready) use a valid/ready handshake. A tick is processed in
// the cycle it is accepted and its result appears in the output register on
// the next cycle; one tick can be taken every cycle while the receiver keeps
// up. The rate is set by the single state update between the state registers
// and the output register.
// When the receiver stalls, the result word holds in the output register and
// in_ready drops until that word is taken; no tick is lost or repeated.
// Reset (rst_n, asynchronous, active low) puts the sequencer in its power-up
// phase with the console held in reset, empties the output register, and
// loads the configuration defaults: stored code 1, debounce 25 ticks, mode
// delay 500 ticks, reset pulse 150 ticks. Configuration is written through
// cfg_we, cfg_index and cfg_data, one register per cycle; the user must write
// it only while the block is idle, and the block itself does not enforce this.
module clock_multiplier_button_selector_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [bsel_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bsel_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             button_pressed,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             mult_pin_low,
    output logic                             mult_pin_high,
    output logic                             led_low,
    output logic                             led_high,
    output logic                             console_reset,
    output logic                             save_strobe,
    output logic [1:0]                       save_value
);
    import bsel_pkg::*;

    cfg_t    cfg;
    result_t fsm_result;
    result_t out_result;
    logic    space;
    logic    accept;

    // A tick is taken whenever the output register has room for its result.
    assign in_ready = space;
    assign accept   = in_valid && space;

    bsel_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bsel_fsm u_fsm (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (accept),
        .button_pressed (button_pressed),
        .cfg            (cfg),
        .result         (fsm_result)
    );

    bsel_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept),
        .result_in  (fsm_result),
        .space      (space),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result_out (out_result)
    );

    // Result word fields go straight to their own ports.
    assign mult_pin_low  = out_result.mult_pin_low;
    assign mult_pin_high = out_result.mult_pin_high;
    assign led_low       = out_result.led_low;
    assign led_high      = out_result.led_high;
    assign console_reset = out_result.console_reset;
    assign save_strobe   = out_result.save_strobe;
    assign save_value    = out_result.save_value;

endmodule
